[design/sha256_pkg.sv]
//------------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and round functions for the message hash.
//------------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	// block buffer write request from the byte packer
	typedef struct packed {
		logic        we;
		logic [3:0]  addr;
		logic [31:0] data;
	} buf_wr_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6A09E667;
			3'd1: r = 32'hBB67AE85;
			3'd2: r = 32'h3C6EF372;
			3'd3: r = 32'hA54FF53A;
			3'd4: r = 32'h510E527F;
			3'd5: r = 32'h9B05688C;
			3'd6: r = 32'h1F83D9AB;
			default: r = 32'h5BE0CD19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0: r = 32'h428A2F98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hB5C0FBCF;
			6'd3: r = 32'hE9B5DBA5; 6'd4: r = 32'h3956C25B; 6'd5: r = 32'h59F111F1;
			6'd6: r = 32'h923F82A4; 6'd7: r = 32'hAB1C5ED5; 6'd8: r = 32'hD807AA98;
			6'd9: r = 32'h12835B01; 6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
			6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE; 6'd14: r = 32'h9BDC06A7;
			6'd15: r = 32'hC19BF174; 6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
			6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC; 6'd20: r = 32'h2DE92C6F;
			6'd21: r = 32'h4A7484AA; 6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
			6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D; 6'd26: r = 32'hB00327C8;
			6'd27: r = 32'hBF597FC7; 6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
			6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27B70A85;
			6'd33: r = 32'h2E1B2138; 6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
			6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB; 6'd38: r = 32'h81C2C92E;
			6'd39: r = 32'h92722C85; 6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
			6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3; 6'd44: r = 32'hD192E819;
			6'd45: r = 32'hD6990624; 6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
			6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08; 6'd50: r = 32'h2748774C;
			6'd51: r = 32'h34B0BCB5; 6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
			6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3; 6'd56: r = 32'h748F82EE;
			6'd57: r = 32'h78A5636F; 6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
			6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB; 6'd62: r = 32'hBEF9A3F7;
			default: r = 32'hC67178F2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage
`default_nettype wire

[design/sha256_message_hash_top.sv]
//------------------------------------------------------------------------------
// SHA-256 message hash, top level
// Streams message bytes in, emits the eight digest words at message end.
//------------------------------------------------------------------------------
//  channel   dir  payload                    handshake
//  in        in   sha256_pkg::in_word_t      in_valid / in_stall
//  out       out  sha256_pkg::out_word_t     out_valid / out_stall
//
//  A byte that does not close a block is taken without a stall. A full block
//  passes the copy, load, round and add phases of the compression engine,
//  one round per cycle through the schedule memory. Message end adds the
//  padding sweep, the two length words, one or two blocks and the 8 digest
//  words, each read from the chain and then presented.
//  Reset restores the initial chain values at once through per-word valid bits.
//  Output stall holds the current digest word; input is stalled while busy.
//------------------------------------------------------------------------------
`default_nettype none
module sha256_message_hash_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire sha256_pkg::in_word_t  in_word,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output sha256_pkg::out_word_t      out_word
);

	logic        start, busy, emit, emit_done;
	logic [3:0]  buf_raddr;
	logic [31:0] buf_rdata, chain_rd_data;
	logic [3:0]  oidx_q;       // next word to read; bit 3 marks done
	logic        rd_pend_q;
	logic        out_on_q;

	sha256_packer u_pack (
		.clk, .arst_n, .in_valid, .in_stall, .in_word,
		.start, .busy, .buf_raddr, .buf_rdata, .emit, .emit_done
	);

	sha256_round u_rnd (
		.clk, .arst_n, .start, .busy, .buf_raddr, .buf_rdata,
		.chain_rd_addr(oidx_q[2:0]),
		.chain_rd_data, .chain_reinit(emit_done)
	);

	assign emit_done = out_on_q && out_valid && !out_stall && out_word.last_word;

	// read chain words one at a time into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_on_q  <= 1'b0;
			oidx_q    <= '0;
			rd_pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				out_on_q  <= 1'b1;
				oidx_q    <= '0;
				rd_pend_q <= 1'b1;
			end else if (rd_pend_q) begin
				// read data is valid this cycle
				out_valid <= 1'b1;
				rd_pend_q <= 1'b0;
				oidx_q    <= oidx_q + 4'd1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
				if (oidx_q[3])
					out_on_q <= 1'b0;
				else
					rd_pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			out_word.digest_word <= chain_rd_data;
			out_word.word_index  <= oidx_q[2:0];
			out_word.last_word   <= (oidx_q[2:0] == 3'd7);
		end
	end

endmodule
`default_nettype wire

[design/sha256_round.sv]
//------------------------------------------------------------------------------
// SHA-256 compression engine
// Copies the block buffer into a schedule memory, runs 64 rounds at one round
// per cycle with read-modify-write of the schedule memory, then adds the
// working words into the chain memory one word per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module sha256_round (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	// block buffer read port (owned by the packer)
	output logic [3:0]       buf_raddr,
	input  wire logic [31:0] buf_rdata,
	// chain read for digest output
	input  wire logic [2:0]  chain_rd_addr,
	output logic [31:0]      chain_rd_data,
	input  wire logic        chain_reinit
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COPY  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;

	logic [2:0]  state_q;
	logic [6:0]  cnt_q;
	logic [31:0] sched_mem [16];
	logic [31:0] chain_mem [8];
	logic [7:0]  chain_ok_q;          // chain entry holds a written value
	logic [31:0] wv_q [8];
	logic [31:0] ch_rdata_q;
	logic [2:0]  ch_idx_q;            // chain entry that ch_rdata_q belongs to
	logic [31:0] sc_w1_q, sc_w2_q, sc_w9_q, sc_w16_q;

	// working words held as a shift row: a..h
	logic [31:0] t1, t2, w_cur, w_new;
	logic [5:0]  rnd;
	logic [3:0]  slot;
	logic [2:0]  ch_idx;
	logic [31:0] ch_val;

	assign busy = (state_q != ST_IDLE);
	assign rnd  = cnt_q[5:0];
	assign slot = cnt_q[3:0];

	// schedule word for this round: stored word for the first 16, else expanded
	assign w_new = sc_w16_q + sha256_pkg::ssig0(sc_w1_q) + sc_w9_q
		+ sha256_pkg::ssig1(sc_w2_q);
	assign w_cur = (rnd < 6'd16) ? sc_w16_q : w_new;

	assign t1 = wv_q[7] + sha256_pkg::bsig1(wv_q[4])
		+ ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
		+ sha256_pkg::round_k(rnd) + w_cur;
	assign t2 = sha256_pkg::bsig0(wv_q[0])
		+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

	assign buf_raddr = cnt_q[3:0];
	// pair the registered read data with the index it was read from
	assign ch_val = chain_ok_q[ch_idx_q] ? ch_rdata_q : sha256_pkg::init_h(ch_idx_q);
	assign chain_rd_data = ch_val;

	// chain read address: digest read when idle, else load or add sweep
	always_comb begin
		if (state_q == ST_IDLE)
			ch_idx = chain_rd_addr;
		else
			ch_idx = cnt_q[2:0];
	end

	always_ff @(posedge clk) begin
		ch_rdata_q <= chain_mem[busy ? cnt_q[2:0] : chain_rd_addr];
	end

	// schedule memory: four registered reads per round, one write-back
	logic [3:0] rd_slot;
	assign rd_slot = (state_q == ST_ROUND) ? slot + 4'd1 : 4'd0;
	always_ff @(posedge clk) begin
		if (state_q == ST_COPY && cnt_q != 7'd0)
			sched_mem[cnt_q[3:0] - 4'd1] <= buf_rdata;
		else if (state_q == ST_ROUND && rnd >= 6'd16)
			sched_mem[slot] <= w_new;
		sc_w16_q <= sched_mem[rd_slot];
		sc_w1_q  <= sched_mem[rd_slot + 4'd1];
		sc_w9_q  <= sched_mem[rd_slot + 4'd9];
		sc_w2_q  <= sched_mem[rd_slot + 4'd14];
		// forward the word being written this cycle
		if (state_q == ST_ROUND && rnd >= 6'd16) begin
			if (rd_slot == slot) sc_w16_q <= w_new;
			if (rd_slot + 4'd1 == slot) sc_w1_q <= w_new;
			if (rd_slot + 4'd9 == slot) sc_w9_q <= w_new;
			if (rd_slot + 4'd14 == slot) sc_w2_q <= w_new;
		end
		if (state_q == ST_COPY && cnt_q != 7'd0) begin
			if (rd_slot == cnt_q[3:0] - 4'd1) sc_w16_q <= buf_rdata;
			if (rd_slot + 4'd1 == cnt_q[3:0] - 4'd1) sc_w1_q <= buf_rdata;
			if (rd_slot + 4'd9 == cnt_q[3:0] - 4'd1) sc_w9_q <= buf_rdata;
			if (rd_slot + 4'd14 == cnt_q[3:0] - 4'd1) sc_w2_q <= buf_rdata;
		end
	end

	// chain memory write-back
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD && cnt_q != 7'd0)
			chain_mem[ch_idx_q] <= ch_val + wv_q[0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			chain_ok_q <= '0;
			ch_idx_q   <= '0;
		end else begin
			ch_idx_q <= ch_idx;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (chain_reinit)
						chain_ok_q <= '0;
					else if (start)
						state_q <= ST_COPY;
				end
				ST_COPY: begin
					// buffer read data is registered; each word is written on the step after its read
					if (cnt_q == 7'd16) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
					end else
						cnt_q <= cnt_q + 7'd1;
				end
				ST_LOAD: begin
					// fill working words from chain, one per cycle (chain read is registered)
					if (cnt_q == 7'd8) begin
						state_q <= ST_ROUND;
						cnt_q   <= '0;
					end else
						cnt_q <= cnt_q + 7'd1;
				end
				ST_ROUND: begin
					if (cnt_q == 7'd63) begin
						state_q <= ST_ADD;
						cnt_q   <= '0;
					end else
						cnt_q <= cnt_q + 7'd1;
				end
				ST_ADD: begin
					if (cnt_q != 7'd0)
						chain_ok_q[ch_idx_q] <= 1'b1;
					if (cnt_q == 7'd8) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else
						cnt_q <= cnt_q + 7'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working words: shift in chain words, run rounds, rotate out for the add
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (cnt_q != 7'd0) begin
					for (int i = 0; i < 7; i++) wv_q[i] <= wv_q[i + 1];
					wv_q[7] <= ch_val;
				end
			end
			ST_ROUND: begin
				wv_q[7] <= wv_q[6]; wv_q[6] <= wv_q[5]; wv_q[5] <= wv_q[4];
				wv_q[4] <= wv_q[3] + t1;
				wv_q[3] <= wv_q[2]; wv_q[2] <= wv_q[1]; wv_q[1] <= wv_q[0];
				wv_q[0] <= t1 + t2;
			end
			ST_ADD: begin
				if (cnt_q != 7'd0) begin
					for (int i = 0; i < 7; i++) wv_q[i] <= wv_q[i + 1];
					wv_q[7] <= wv_q[0];
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[design/sha256_packer.sv]
//------------------------------------------------------------------------------
// SHA-256 byte packer
// Packs message bytes big-endian into the block buffer memory, adds padding
// and length words, and hands full blocks to the compression engine.
//------------------------------------------------------------------------------
`default_nettype none
module sha256_packer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire sha256_pkg::in_word_t in_word,
	output logic                      start,
	input  wire logic                 busy,
	input  wire logic [3:0]           buf_raddr,
	output logic [31:0]               buf_rdata,
	output logic                      emit,        // pulse: digest ready
	input  wire logic                 emit_done
);

	localparam logic [2:0] PK_IDLE  = 3'd0;
	localparam logic [2:0] PK_WAIT  = 3'd1;  // block compressing
	localparam logic [2:0] PK_PAD   = 3'd2;  // write pad byte / zero fill
	localparam logic [2:0] PK_LEN   = 3'd3;  // write length words
	localparam logic [2:0] PK_FIN   = 3'd4;  // last block compressing
	localparam logic [2:0] PK_OUT   = 3'd5;  // digest going out

	logic [2:0]  state_q;
	logic [63:0] bit_count_q;
	logic [31:0] buf_mem [16];
	logic [31:0] acc_q;          // partial word being assembled
	logic        end_q;          // message end still to handle
	logic        pad_first_q;    // pad byte not yet placed
	logic        len_hi_q;
	logic [5:0]  pos_q;          // byte position during padding
	logic        start_q;
	sha256_pkg::buf_wr_t wr;

	logic [5:0]  pos;
	logic        take;
	logic [31:0] acc_next;
	logic [7:0]  pad_b;

	assign pos      = bit_count_q[8:3];
	assign in_stall = (state_q != PK_IDLE);
	assign take     = in_valid && !in_stall;
	assign pad_b    = pad_first_q ? sha256_pkg::PAD_BYTE : 8'h00;

	// merge a byte into the word being assembled
	function automatic logic [31:0] merge(input logic [31:0] a, input logic [1:0] p,
		input logic [7:0] b);
		logic [31:0] r;
		r = (p == 2'd0) ? 32'h0 : a;
		r[8'(3 - p) * 8 +: 8] = b;
		return r;
	endfunction

	always_comb begin
		wr = '0;
		acc_next = acc_q;
		if (state_q == PK_IDLE && take && in_word.byte_present) begin
			acc_next = merge(acc_q, pos[1:0], in_word.data_byte);
			wr.we    = (pos[1:0] == 2'd3);
			wr.addr  = pos[5:2];
			wr.data  = acc_next;
		end else if (state_q == PK_PAD) begin
			acc_next = merge(acc_q, pos_q[1:0], pad_b);
			wr.we    = (pos_q[1:0] == 2'd3);
			wr.addr  = pos_q[5:2];
			wr.data  = acc_next;
		end else if (state_q == PK_LEN) begin
			wr.we    = 1'b1;
			wr.addr  = len_hi_q ? 4'd14 : 4'd15;
			wr.data  = len_hi_q ? bit_count_q[63:32] : bit_count_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we)
			buf_mem[wr.addr] <= wr.data;
		buf_rdata <= buf_mem[buf_raddr];
		acc_q <= acc_next;
	end

	assign start = (state_q == PK_IDLE && take && in_word.byte_present && pos == 6'd63)
		|| (state_q == PK_PAD && pos_q == 6'd63)
		|| (state_q == PK_LEN && !len_hi_q);

	assign emit = (state_q == PK_FIN) && !busy && !start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PK_IDLE;
			bit_count_q <= '0;
			end_q       <= 1'b0;
			pad_first_q <= 1'b0;
			len_hi_q    <= 1'b0;
			pos_q       <= '0;
			start_q     <= 1'b0;
		end else begin
			start_q <= start;
			case (state_q)
				PK_IDLE: begin
					if (take) begin
						if (in_word.byte_present)
							bit_count_q <= bit_count_q + 64'd8;
						end_q       <= in_word.message_end;
						pad_first_q <= 1'b1;
						pos_q       <= in_word.byte_present ? pos + 6'd1 : pos;
						if (in_word.byte_present && pos == 6'd63)
							state_q <= PK_WAIT;
						else if (in_word.message_end)
							state_q <= PK_PAD;
					end
				end
				PK_WAIT: begin
					if (!busy && !start_q)
						state_q <= end_q ? PK_PAD : PK_IDLE;
				end
				PK_PAD: begin
					pad_first_q <= 1'b0;
					pos_q       <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						end_q   <= 1'b1;
						state_q <= PK_WAIT;
					end else if (pos_q == sha256_pkg::LEN_POS - 6'd1 && !pad_first_q) begin
						len_hi_q <= 1'b1;
						state_q  <= PK_LEN;
					end else if (pos_q == sha256_pkg::LEN_POS - 6'd1) begin
						// pad byte lands in the last zero-fill slot
						len_hi_q <= 1'b1;
						state_q  <= PK_LEN;
					end
				end
				PK_LEN: begin
					len_hi_q <= 1'b0;
					if (!len_hi_q)
						state_q <= PK_FIN;
				end
				PK_FIN: begin
					if (emit)
						state_q <= PK_OUT;
				end
				PK_OUT: begin
					if (emit_done) begin
						bit_count_q <= '0;
						end_q       <= 1'b0;
						state_q     <= PK_IDLE;
					end
				end
				default: state_q <= PK_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[bench/sha256_message_hash_top_tb.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// SHA-256 message hash testbench
// Streams byte messages into the hash block under random idling on both sides
// and compares every digest word against a behavioral SHA-256 model.
//------------------------------------------------------------------------------
`default_nettype none
module sha256_message_hash_top_tb;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	sha256_pkg::in_word_t  in_word;
	logic                  out_valid;
	logic                  out_stall;
	sha256_pkg::out_word_t out_word;

	// idle rates in percent
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned n_errors;
	sha256_pkg::out_word_t digest_q[$];

	// model state
	logic [31:0] hash_state[8];
	logic [7:0]  msg_bytes[64];
	logic [63:0] msg_bits;

	localparam logic [31:0] K_TAB[64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
		32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
		32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
		32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
		32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
		32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
	localparam logic [31:0] H_INIT[8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372,
		32'hA54FF53A, 32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

	sha256_message_hash_top uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
		.out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// fold the 64 gathered bytes into the hash state
	task automatic fold_block();
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_bytes[4*i], msg_bytes[4*i+1], msg_bytes[4*i+2], msg_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
		{a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
			hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TAB[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) ^ 32'h0;
			t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	// advance the model by one accepted word, queue any digest words
	task automatic hash_predict(sha256_pkg::in_word_t iw);
		int p;
		sha256_pkg::out_word_t ow;
		if (iw.byte_present) begin
			p = int'(msg_bits[8:3]);
			msg_bytes[p] = iw.data_byte;
			msg_bits += 64'd8;
			if (p == 63) fold_block();
		end
		if (iw.message_end) begin
			p = int'(msg_bits[8:3]);
			msg_bytes[p] = 8'h80;
			p++;
			if (p > 56) begin
				while (p < 64) msg_bytes[p++] = 8'h00;
				fold_block();
				p = 0;
			end
			while (p < 56) msg_bytes[p++] = 8'h00;
			for (int i = 0; i < 8; i++) msg_bytes[56+i] = msg_bits[63-8*i -: 8];
			fold_block();
			for (int i = 0; i < 8; i++) begin
				ow.digest_word = hash_state[i];
				ow.word_index = 3'(i);
				ow.last_word = (i == 7);
				digest_q.push_back(ow);
			end
			hash_state = H_INIT;
			msg_bits = '0;
		end
	endtask

	// send one word, idling at random beforehand; valid stays up on return
	task automatic send_word(logic [7:0] b, logic present, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{data_byte: b, byte_present: present, message_end: fin};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hash_predict(in_word);
		@(negedge clk);
	endtask

	task automatic send_message(int len, logic with_holes);
		for (int i = 0; i < len; i++) begin
			if (with_holes && $urandom_range(7) == 0)
				send_word(8'($urandom), 1'b0, 1'b0);
			send_word(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
		end
		if (len == 0 || in_word.message_end == 1'b0)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	// drop valid and hold off until every expected digest word is out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (digest_q.size() != 0);
	endtask

	// directed: empty message, all-ones and all-zeros bytes, idle words
	task automatic test_directed();
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hFF, 1'b1, 1'b1);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hA5, 1'b0, 1'b0);
		send_word(8'h5A, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		wait_drained();
	endtask

	// padding that spills into a second final block
	task automatic test_boundaries();
		send_message(60, 1'b0);
		wait_drained();
	endtask

	// random short messages with stray idle words
	task automatic test_random(int n_bytes);
		int sent;
		int len;
		sent = 0;
		while (sent < n_bytes) begin
			len = $urandom_range(12);
			send_message(len, 1'b1);
			sent += len + 1;
		end
		wait_drained();
	endtask

	// check each accepted digest word against the oldest prediction
	always @(posedge clk) begin
		sha256_pkg::out_word_t ex;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$error("digest word with none expected: %h", out_word);
				n_errors++;
			end else begin
				ex = digest_q.pop_front();
				if (out_word.digest_word !== ex.digest_word) begin
					$error("digest_word exp %h got %h", ex.digest_word, out_word.digest_word);
					n_errors++;
				end
				if (out_word.word_index !== ex.word_index) begin
					$error("word_index exp %0d got %0d", ex.word_index, out_word.word_index);
					n_errors++;
				end
				if (out_word.last_word !== ex.last_word) begin
					$error("last_word exp %0d got %0d", ex.last_word, out_word.last_word);
					n_errors++;
				end
			end
		end
	end

	// receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	initial begin
		#20ms;
		$display("sha256_message_hash_top_tb NOT OK");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		n_errors = 0;
		hash_state = H_INIT;
		msg_bits = '0;
		send_idle_pct = 21;
		recv_idle_pct = 76;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_boundaries();
		test_random(10);
		send_idle_pct = 76;
		recv_idle_pct = 21;
		test_random(12);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(12);
		repeat (300) @(negedge clk);
		if (n_errors == 0 && digest_q.size() == 0)
			$display("sha256_message_hash_top_tb OK");
		else
			$display("sha256_message_hash_top_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
